FILE: rtl/tkls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkls_pkg: shared types and constants for the top-K pose list
// Field widths, stream packing, control/status bundles and the mode codes.
// ----------------------------------------------------------------------------
package tkls_pkg;

  localparam int MAX_KEEP_DEF   = 16;
  localparam int SCORE_W        = 40;
  localparam int POS_W          = 24;
  localparam int ANG_W          = 9;
  localparam int MODE_W         = 2;
  localparam int KEEP_W         = 5;
  localparam int RES_W          = 16;
  localparam int SIZE_W         = 5;
  localparam int SUPPRESS_STEPS = 3;
  localparam int RAD_W          = RES_W + 2;
  localparam int DIFF_W         = POS_W + 1;
  localparam int MUL_W          = DIFF_W + 1;
  localparam int SQ_W           = 2 * POS_W;
  localparam int R2_W           = 2 * RAD_W;
  localparam int D2_W           = SQ_W + 2;
  localparam int IN_DATA_W      = 144;
  localparam int OUT_DATA_W     = 152;
  localparam logic [RES_W-1:0] RES_RESET = RES_W'(256);

  // configuration register indexes
  localparam logic CFG_KEEP = 1'b0;
  localparam logic CFG_RES  = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_OFFER = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    MS_R = 2'd0,
    MS_X = 2'd1,
    MS_Y = 2'd2,
    MS_Z = 2'd3
  } mul_sel_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic signed [POS_W-1:0]   x;
    logic signed [POS_W-1:0]   y;
    logic signed [POS_W-1:0]   z;
    logic [ANG_W-1:0]          ax;
    logic [ANG_W-1:0]          ay;
    logic [ANG_W-1:0]          az;
  } pose_t;

  // controller -> datapath
  typedef struct packed {
    logic     load_cand;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     idx_worst;
    logic     idx_clr;
    logic     idx_inc;
    logic     scan_init;
    logic     acc_load;
    logic     acc_add;
    logic     scan_cmp;
    logic     kill_one;
    logic     insert;
    logic     shrink;
    logic     held_clr;
    logic     emit_stat;
    logic     emit_entry;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic k_zero;
    logic consider;
    logic held_zero;
    logic idx_last;
    logic reject;
    logic any_kill;
    logic held_over;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/tkls_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkls_ctrl: sequencer for the top-K pose list
// Steps each item through worst check, neighbour scan, removal, insertion,
// trimming and result output; also reads out or clears the list.
// ----------------------------------------------------------------------------
module tkls_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  tkls_pkg::mode_t      in_mode,
  output logic                 in_ready,
  input  tkls_pkg::sts_t       sts,
  output tkls_pkg::cmd_t       cmd
);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_PREP  = 14'b00000000000010,
    S_CHK   = 14'b00000000000100,
    S_SX    = 14'b00000000001000,
    S_SY    = 14'b00000000010000,
    S_SZ    = 14'b00000000100000,
    S_SCMP  = 14'b00000001000000,
    S_KILL  = 14'b00000010000000,
    S_INS   = 14'b00000100000000,
    S_FIN   = 14'b00001000000000,
    S_CLR   = 14'b00010000000000,
    S_READ  = 14'b00100000000000,
    S_RDOUT = 14'b01000000000000,
    S_EMIT  = 14'b10000000000000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.mul_sel = tkls_pkg::MS_R;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_cand = 1'b1;
          case (in_mode)
            tkls_pkg::MODE_OFFER: state_next = sts.k_zero ? S_EMIT : S_PREP;
            tkls_pkg::MODE_READ:  state_next = S_READ;
            tkls_pkg::MODE_CLEAR: state_next = S_CLR;
            default:              state_next = S_EMIT;
          endcase
        end
      end
      S_PREP: begin
        // square the suppression radius, point at the worst entry
        cmd.mul_en    = 1'b1;
        cmd.mul_sel   = tkls_pkg::MS_R;
        cmd.idx_worst = 1'b1;
        state_next    = S_CHK;
      end
      S_CHK: begin
        cmd.scan_init = 1'b1;
        cmd.idx_clr   = 1'b1;
        if (!sts.consider) begin
          state_next = S_FIN;
        end else if (sts.held_zero) begin
          state_next = S_INS;
        end else begin
          state_next = S_SX;
        end
      end
      S_SX: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = tkls_pkg::MS_X;
        state_next  = S_SY;
      end
      S_SY: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = tkls_pkg::MS_Y;
        cmd.acc_load = 1'b1;
        state_next   = S_SZ;
      end
      S_SZ: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = tkls_pkg::MS_Z;
        cmd.acc_add = 1'b1;
        state_next  = S_SCMP;
      end
      S_SCMP: begin
        if (sts.reject) begin
          state_next = S_FIN;
        end else begin
          cmd.scan_cmp = 1'b1;
          if (sts.idx_last) begin
            state_next = S_KILL;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_SX;
          end
        end
      end
      S_KILL: begin
        if (sts.any_kill) begin
          cmd.kill_one = 1'b1;
        end else begin
          state_next = S_INS;
        end
      end
      S_INS: begin
        cmd.insert = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.shrink = sts.held_over;
        state_next = S_EMIT;
      end
      S_CLR: begin
        cmd.held_clr = 1'b1;
        state_next   = S_EMIT;
      end
      S_READ: begin
        cmd.idx_clr = 1'b1;
        state_next  = sts.held_zero ? S_EMIT : S_RDOUT;
      end
      S_RDOUT: begin
        if (sts.out_free) begin
          cmd.emit_entry = 1'b1;
          if (sts.idx_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_stat = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: rtl/tkls_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkls_dp: datapath of the top-K pose list
// Entry registers, shared squaring multiplier, distance accumulator,
// kill flags, insert/remove shifters and the output register.
// ----------------------------------------------------------------------------
module tkls_dp #(
  parameter int MAX_KEEP = tkls_pkg::MAX_KEEP_DEF,
  parameter int IW       = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1,
  parameter int CW       = $clog2(MAX_KEEP + 2)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  tkls_pkg::cmd_t                    cmd,
  output tkls_pkg::sts_t                    sts,
  input  logic [tkls_pkg::IN_DATA_W-1:0]    in_data,
  input  logic [CW-1:0]                     k,
  input  logic [tkls_pkg::RAD_W-1:0]        radius,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [tkls_pkg::OUT_DATA_W-1:0]   out_data,
  output logic                              out_user,
  output logic                              out_last
);

  tkls_pkg::pose_t entry [MAX_KEEP];
  tkls_pkg::pose_t cand;
  tkls_pkg::pose_t cand_in;
  tkls_pkg::pose_t rd;
  logic [MAX_KEEP-1:0]            kill;
  logic [CW-1:0]                  held;
  logic [CW-1:0]                  le_cnt;
  logic [IW-1:0]                  idx;
  logic [IW-1:0]                  kpos;
  logic                           acc_flag;
  logic [tkls_pkg::SQ_W-1:0]      prod;
  logic [tkls_pkg::SQ_W:0]        acc;
  logic [tkls_pkg::R2_W-1:0]      r2;
  logic signed [tkls_pkg::DIFF_W-1:0] diff;
  logic signed [tkls_pkg::MUL_W-1:0]  mul_a;
  logic signed [2*tkls_pkg::MUL_W-1:0] mul_p;
  logic [tkls_pkg::D2_W-1:0]      d2;
  logic                           near;
  tkls_pkg::pose_t                o_pose;
  logic                           o_acc;
  logic [CW-1:0]                  o_size;
  logic                           o_valid_entry;

  // input unpacking, first field lowest
  assign cand_in.score = in_data[39:0];
  assign cand_in.x     = in_data[63:40];
  assign cand_in.y     = in_data[87:64];
  assign cand_in.z     = in_data[111:88];
  assign cand_in.ax    = in_data[120:112];
  assign cand_in.ay    = in_data[129:121];
  assign cand_in.az    = in_data[138:130];

  assign rd = entry[idx];

  // coordinate difference and squaring
  always_comb begin
    case (cmd.mul_sel)
      tkls_pkg::MS_X: diff = {rd.x[tkls_pkg::POS_W-1], rd.x} - {cand.x[tkls_pkg::POS_W-1], cand.x};
      tkls_pkg::MS_Y: diff = {rd.y[tkls_pkg::POS_W-1], rd.y} - {cand.y[tkls_pkg::POS_W-1], cand.y};
      default:        diff = {rd.z[tkls_pkg::POS_W-1], rd.z} - {cand.z[tkls_pkg::POS_W-1], cand.z};
    endcase
    if (cmd.mul_sel == tkls_pkg::MS_R) begin
      mul_a = $signed({{(tkls_pkg::MUL_W-tkls_pkg::RAD_W){1'b0}}, radius});
    end else begin
      mul_a = {diff[tkls_pkg::DIFF_W-1], diff};
    end
  end
  assign mul_p = mul_a * mul_a;

  assign d2   = {1'b0, acc} + {2'b0, prod};
  assign near = d2 < {{(tkls_pkg::D2_W-tkls_pkg::R2_W){1'b0}}, r2};

  // lowest flagged entry
  always_comb begin
    kpos = '0;
    for (int j = MAX_KEEP - 1; j >= 0; j--) begin
      if (kill[j]) kpos = IW'(j);
    end
  end

  // status
  always_comb begin
    sts.k_zero    = (k == '0);
    sts.held_zero = (held == '0);
    sts.consider  = (held < k) || ((held != '0) && (cand.score < rd.score));
    sts.idx_last  = (CW'(idx) == held - CW'(1));
    sts.reject    = near && !(cand.score < rd.score);
    sts.any_kill  = |kill;
    sts.held_over = (held > k);
    sts.out_free  = !out_valid || out_ready;
  end

  // candidate, multiplier and scan registers
  always_ff @(posedge clk) begin
    if (cmd.load_cand) cand <= cand_in;
    if (cmd.mul_en) prod <= mul_p[tkls_pkg::SQ_W-1:0];
    if (cmd.scan_init) r2 <= prod[tkls_pkg::R2_W-1:0];
    if (cmd.acc_load) begin
      acc <= {1'b0, prod};
    end else if (cmd.acc_add) begin
      acc <= acc + {1'b0, prod};
    end
  end

  // control registers of the datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      held     <= '0;
      idx      <= '0;
      le_cnt   <= '0;
      kill     <= '0;
      acc_flag <= 1'b0;
    end else begin
      if (cmd.load_cand) acc_flag <= 1'b0;
      if (cmd.idx_worst) begin
        idx <= IW'(held - CW'(1));
      end else if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + IW'(1);
      end
      if (cmd.scan_init) begin
        le_cnt <= '0;
        kill   <= '0;
      end
      if (cmd.scan_cmp) begin
        if (near) kill[idx] <= 1'b1;
        if (rd.score <= cand.score) le_cnt <= le_cnt + CW'(1);
      end
      if (cmd.kill_one) begin
        for (int j = 0; j < MAX_KEEP; j++) begin
          if (IW'(j) >= kpos) kill[j] <= (j + 1 < MAX_KEEP) ? kill[(j + 1 < MAX_KEEP) ? j + 1 : j] : 1'b0;
        end
        held <= held - CW'(1);
      end
      if (cmd.insert) begin
        held     <= held + CW'(1);
        acc_flag <= 1'b1;
      end
      if (cmd.shrink) held <= held - CW'(1);
      if (cmd.held_clr) held <= '0;
    end
  end

  // entry shifters: close a gap on removal, open one on insertion
  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_KEEP; j++) begin
      if (cmd.kill_one && (IW'(j) >= kpos) && (j + 1 < MAX_KEEP)) begin
        entry[j] <= entry[(j + 1 < MAX_KEEP) ? j + 1 : j];
      end else if (cmd.insert) begin
        if (CW'(j) == le_cnt) begin
          entry[j] <= cand;
        end else if ((CW'(j) > le_cnt) && (j > 0)) begin
          entry[j] <= entry[(j > 0) ? j - 1 : j];
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_stat || cmd.emit_entry) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_stat) begin
      o_acc         <= acc_flag;
      o_size        <= held;
      o_valid_entry <= 1'b0;
      o_pose        <= '0;
      out_last      <= 1'b1;
    end else if (cmd.emit_entry) begin
      o_acc         <= 1'b0;
      o_size        <= held;
      o_valid_entry <= 1'b1;
      o_pose        <= rd;
      out_last      <= sts.idx_last;
    end
  end

  assign out_user = o_valid_entry;
  assign out_data = {7'b0, o_pose.az, o_pose.ay, o_pose.ax, o_pose.z, o_pose.y, o_pose.x,
                     o_pose.score, tkls_pkg::SIZE_W'(o_size), o_acc};

endmodule

FILE: rtl/top_k_list_with_distance_suppression_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_list_with_distance_suppression_unit: top-K pose list with suppression
// Keeps the best poses by ascending score, removing near neighbours of a
// better candidate; reads the list out in order or clears it.
// ----------------------------------------------------------------------------
// Offer: the held entries are scanned through one shared squaring multiplier,
//   three products per entry, then near neighbours are removed one by one.
// Readout: one result per entry per cycle while the output is not stalled;
//   clear, unused mode or offer with the list disabled: one status result.
// One item at a time; the next item is taken once the last result is loaded.
// Reset: list empty, keep_count 0 (offers ignored), grid_resolution 256.
// ----------------------------------------------------------------------------
module top_k_list_with_distance_suppression_unit #(
  parameter int MAX_KEEP = tkls_pkg::MAX_KEEP_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // candidate_score, cand_x, cand_y, cand_z, cand_angle_x, _y, _z, zero pad
  input  logic [tkls_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // mode
  input  logic [tkls_pkg::MODE_W-1:0]     s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // accepted, list_size, out_score, out_x, out_y, out_z, out_angle_x, _y, _z, pad
  output logic [tkls_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // entry_valid
  output logic                            m_axis_tuser,
  output logic                            m_axis_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_index,
  input  logic [tkls_pkg::RES_W-1:0]      cfg_data
);

  localparam int CW = $clog2(MAX_KEEP + 2);

  logic [tkls_pkg::KEEP_W-1:0] keep_count;
  logic [tkls_pkg::RES_W-1:0]  grid_resolution;
  logic [CW-1:0]               k;
  logic [tkls_pkg::RAD_W-1:0]  radius;
  tkls_pkg::cmd_t              cmd;
  tkls_pkg::sts_t              sts;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count      <= '0;
      grid_resolution <= tkls_pkg::RES_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        tkls_pkg::CFG_KEEP: keep_count      <= cfg_data[tkls_pkg::KEEP_W-1:0];
        tkls_pkg::CFG_RES:  grid_resolution <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective list length and suppression radius
  always_comb begin
    if (int'(keep_count) > MAX_KEEP) begin
      k = CW'(MAX_KEEP);
    end else begin
      k = CW'(keep_count);
    end
    radius = tkls_pkg::RAD_W'(tkls_pkg::SUPPRESS_STEPS) * {2'b0, grid_resolution};
  end

  tkls_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_mode  (tkls_pkg::mode_t'(s_axis_tuser)),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tkls_dp #(
    .MAX_KEEP (MAX_KEEP)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (s_axis_tdata),
    .k         (k),
    .radius    (radius),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata),
    .out_user  (m_axis_tuser),
    .out_last  (m_axis_tlast)
  );

endmodule

FILE: rtl/tkls_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkls_checker: port-level checks for the top-K pose list
// Watches the stream ports and flags handshake and result-format slips.
// ----------------------------------------------------------------------------
module tkls_checker #(
  parameter int MAX_KEEP = tkls_pkg::MAX_KEEP_DEF
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [tkls_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input logic [tkls_pkg::MODE_W-1:0]     s_axis_tuser,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [tkls_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tuser,
  input logic                            m_axis_tlast,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic                            cfg_index,
  input logic [tkls_pkg::RES_W-1:0]      cfg_data
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result withdrawn while stalled");

  // one item in flight: no second item right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken twice in a row");

  // list size never above capacity
  a_size: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (int'(m_axis_tdata[5:1]) <= MAX_KEEP))
    else $error("list size above capacity");

  // only readout entries can be followed by more results
  a_non_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser)
    else $error("non-final result without entry");

  // an offer result carries no entry
  a_acc_entry: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[0] |-> !m_axis_tuser && m_axis_tlast)
    else $error("accept flag on readout entry");

endmodule

bind top_k_list_with_distance_suppression_unit tkls_checker #(
  .MAX_KEEP (MAX_KEEP)
) u_tkls_checker (.*);
